FILE: hw/rtl/tboa_pkg.sv
// Shared types and constants for the time-bin occupancy averager.
// Used by tboa_div, time_bin_occupancy_averager, tboa_checker and the testbench.
// No dependencies.
package tboa_pkg;

  // Operation codes carried in s_tuser.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_BIN_WIDTH   = 2'd0;
  localparam logic [1:0] REG_WINDOW_HALF = 2'd1;
  localparam logic [1:0] REG_ACTIVE_BINS = 2'd2;

  // Field and bus widths.
  localparam int OP_W         = 2;
  localparam int TIME_W       = 20;
  localparam int QBIN_W       = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;
  localparam int CNT_W        = 32;
  localparam int ACT_W        = 11;
  localparam int WIN_W        = 8;
  localparam int WCNT_W       = 9;

  // Divider geometry: 32-bit dividend, 16-bit divisor, one bit per cycle.
  localparam int DIV_W        = 32;
  localparam int DVS_W        = 16;
  localparam int DIV_CNT_W    = $clog2(DIV_W);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hw/rtl/tboa_div.sv
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on tboa_pkg for the request and response types.
module tboa_div import tboa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W:0]       rem_shift;
  logic [DVS_W:0]       diff;
  logic                 q_bit;
  logic [DVS_W-1:0]     rem_next;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem, quo[DIV_W-1]};
    diff      = rem_shift - {1'b0, dvs};
    q_bit     = ~diff[DVS_W];
    rem_next  = q_bit ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
  end

  // Control: step counter, busy and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: hw/rtl/time_bin_occupancy_averager.sv
// Add: accept, divider, counter read and write, then the result beat.
// Query: accept, window sum (one counter read per cycle), divider, result beat.
// Clear: a sweep of the counter memory, then the result beat.
// One item at a time; the 32-step shared divider sets the add and query time.
// Reset (rst, synchronous) restores the registers and sweeps the counter memory
// to zero, one entry per cycle, with s_tready low meanwhile.
module time_bin_occupancy_averager import tboa_pkg::*; #(
  parameter int MAX_BINS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input beat.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // cluster_time[19:0], bin_index[29:20], zero pad
  input  logic [OP_W-1:0]        s_tuser,   // opcode[1:0]
  // Result beat.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // average[31:0], status[32], zero pad
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int          BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [16:0] MAX_BINS_V = 17'(MAX_BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_BINS - 1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_CLEAR   = 11'b000_0000_0010,
    S_ADIV    = 11'b000_0000_0100,
    S_RD      = 11'b000_0000_1000,
    S_WR      = 11'b000_0001_0000,
    S_SUM     = 11'b000_0010_0000,
    S_SUM_END = 11'b000_0100_0000,
    S_QSTART  = 11'b000_1000_0000,
    S_QDIV    = 11'b001_0000_0000,
    S_DONE    = 11'b010_0000_0000,
    S_SPARE   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  logic [DVS_W-1:0]  bin_width;
  logic [WIN_W-1:0]  window_half;
  logic [ACT_W-1:0]  active_bins;
  logic [ACT_W-1:0]  nact;

  logic [OP_W-1:0]   in_op;
  logic [TIME_W-1:0] in_time;
  logic [QBIN_W-1:0] in_bin;
  logic              accept;
  logic              in_bin_bad;

  logic [QBIN_W-1:0] q_lo;
  logic [ACT_W-1:0]  q_hi_raw;
  logic [ACT_W-1:0]  q_hi;

  logic [ACT_W-1:0]  win_idx;
  logic [ACT_W-1:0]  win_last;
  logic [WCNT_W-1:0] win_cnt;
  logic [CNT_W-1:0]  sum;
  logic              sum_vld;

  logic [BIN_W-1:0]  clr_addr;
  logic              clr_op;
  logic [BIN_W-1:0]  bin_addr;
  logic              quot_bad;

  logic [CNT_W-1:0]  res_avg;
  logic              res_status;
  logic              out_load;

  logic [CNT_W-1:0]  mem [MAX_BINS];
  logic [CNT_W-1:0]  rd_data;
  logic              mem_we;
  logic [BIN_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic [BIN_W-1:0]  mem_raddr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers; writes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width   <= DVS_W'(1);
      window_half <= '0;
      active_bins <= ACT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIN_WIDTH:   bin_width   <= cfg_data;
        REG_WINDOW_HALF: window_half <= cfg_data[WIN_W-1:0];
        REG_ACTIVE_BINS: active_bins <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Number of bins in use, limited by the memory depth.
  assign nact = (17'(active_bins) < MAX_BINS_V) ? active_bins : ACT_W'(MAX_BINS);

  // Input beat unpacking.
  assign in_op      = s_tuser;
  assign in_time    = s_tdata[TIME_W-1:0];
  assign in_bin     = s_tdata[TIME_W +: QBIN_W];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign in_bin_bad = (ACT_W'(in_bin) >= nact);

  // Query window bounds, clamped to zero below and to the active bins above.
  always_comb begin
    q_lo     = (in_bin > QBIN_W'(window_half)) ? in_bin - QBIN_W'(window_half) : '0;
    q_hi_raw = ACT_W'(in_bin) + ACT_W'(window_half) + ACT_W'(1);
    q_hi     = (q_hi_raw > nact) ? nact : q_hi_raw;
  end

  // Shared divider: bin number on an add, window mean on a query.
  always_comb begin
    div_req.start    = (accept && (in_op == OP_ADD) && (bin_width != '0)) ||
                       (state == S_QSTART);
    div_req.dividend = (state == S_QSTART) ? sum : DIV_W'(in_time);
    div_req.divisor  = (state == S_QSTART) ? DVS_W'(win_cnt) : bin_width;
  end

  tboa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign quot_bad = (div_rsp.quotient >= DIV_W'(nact));
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ADD:   state_next = (bin_width == '0) ? S_DONE : S_ADIV;
            OP_QUERY: state_next = in_bin_bad ? S_DONE : S_SUM;
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_addr == LAST_BIN) begin
          state_next = clr_op ? S_DONE : S_IDLE;
        end
      end
      S_ADIV: begin
        if (div_rsp.done) begin
          state_next = quot_bad ? S_DONE : S_RD;
        end
      end
      S_RD:      state_next = S_WR;
      S_WR:      state_next = S_DONE;
      S_SUM: begin
        if (win_idx == win_last) begin
          state_next = S_SUM_END;
        end
      end
      S_SUM_END: state_next = S_QSTART;
      S_QSTART:  state_next = S_QDIV;
      S_QDIV: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Control registers: state, clearing sweep and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_op   <= 1'b0;
      sum_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      sum_vld <= (state == S_SUM);
      if (state == S_CLEAR) begin
        clr_addr <= (clr_addr == LAST_BIN) ? '0 : clr_addr + 1'b1;
      end
      if (accept) begin
        clr_op <= (in_op == OP_CLEAR);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers: window walk, running sum and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      sum        <= '0;
      res_avg    <= '0;
      res_status <= ((in_op == OP_ADD) && (bin_width == '0)) ||
                    ((in_op == OP_QUERY) && in_bin_bad);
      win_idx    <= ACT_W'(q_lo);
      win_last   <= q_hi - ACT_W'(1);
      win_cnt    <= WCNT_W'(q_hi - ACT_W'(q_lo));
    end
    if (sum_vld) begin
      sum <= sum + rd_data;
    end
    if (state == S_SUM) begin
      win_idx <= win_idx + 1'b1;
    end
    if ((state == S_ADIV) && div_rsp.done) begin
      res_status <= quot_bad;
      bin_addr   <= BIN_W'(div_rsp.quotient);
    end
    if ((state == S_QDIV) && div_rsp.done) begin
      res_avg <= div_rsp.quotient;
    end
    if (out_load) begin
      m_tdata <= {7'b0, res_status, res_avg};
    end
  end

  // Counter memory: one write and one registered read per cycle.
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_WR);
    mem_waddr = (state == S_CLEAR) ? clr_addr : bin_addr;
    mem_wdata = (state == S_CLEAR) ? '0 :
                ((rd_data == CNT_MAX) ? rd_data : rd_data + 1'b1);
    mem_raddr = (state == S_SUM) ? BIN_W'(win_idx) : bin_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

endmodule

FILE: hw/rtl/tboa_checker.sv
// Port-level checks for the time-bin occupancy averager, bound to the top level.
// Depends on tboa_pkg for bus widths.
module tboa_checker import tboa_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // Reset starts the clearing sweep: no input taken, no result shown.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!s_tready && !m_tvalid))
    else $error("block ready or result valid right after reset");

  // Every accepted beat leaves the block busy in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("block ready again in the cycle after an accepted beat");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // A set status bit always comes with a zero average and zero padding.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == '0 && m_tdata[39:33] == '0))
    else $error("flagged result carries a nonzero average");

endmodule

bind time_bin_occupancy_averager tboa_checker u_tboa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/tb_time_bin_occupancy_averager.sv
// Self-checking testbench for time_bin_occupancy_averager: adds, queries, clears
// and unused opcodes under several register settings, checked against an in-bench predictor.
// Depends on tboa_pkg and the time_bin_occupancy_averager RTL.
module tb_time_bin_occupancy_averager;
  import tboa_pkg::*;

  localparam int MAX_BINS     = 1024;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int SETTLE       = 1200;

  // Opcode with no defined operation; the block answers it with a zero beat.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] average;
    logic             status;
  } occupancy_result_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // cluster_time[19:0], bin_index[29:20], zero pad
  logic [OP_W-1:0]        s_tuser = '0;   // opcode[1:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // average[31:0], status[32], zero pad
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow of the block: counters and registers.
  logic [CNT_W-1:0]  occupancy [MAX_BINS];
  logic [15:0]       bin_width = 16'd1;
  logic [WIN_W-1:0]  window_half = '0;
  logic [ACT_W-1:0]  active_bins = ACT_W'(1024);

  occupancy_result_t awaited_results [$];
  int unsigned       in_beats = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  bit                idling_on = 1'b0;
  int unsigned       stall_left = 0;

  time_bin_occupancy_averager #(.MAX_BINS(MAX_BINS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < MAX_BINS; i++) occupancy[i] = '0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned live_bins();
    return (active_bins < MAX_BINS) ? active_bins : MAX_BINS;
  endfunction

  // Applies one operation to the shadow counters and returns the result beat it should cause.
  function automatic occupancy_result_t apply_occupancy_op(logic [OP_W-1:0] op,
                                                           logic [TIME_W-1:0] ctime,
                                                           logic [QBIN_W-1:0] qbin);
    occupancy_result_t res;
    int unsigned       nact, bin, lo, hi;
    logic [CNT_W-1:0]  sum;
    res = '0;
    nact = live_bins();
    case (op)
      OP_ADD: begin
        if (bin_width == 0) begin
          res.status = 1'b1;
        end else begin
          bin = ctime / bin_width;
          if (bin >= nact) res.status = 1'b1;
          else if (occupancy[bin] != CNT_MAX) occupancy[bin] = occupancy[bin] + 1;
        end
      end
      OP_QUERY: begin
        bin = qbin;
        if (bin >= nact) begin
          res.status = 1'b1;
        end else begin
          lo = (bin > window_half) ? bin - window_half : 0;
          hi = bin + window_half + 1;
          if (hi > nact) hi = nact;
          sum = '0;
          for (int unsigned i = lo; i < hi; i++) sum = sum + occupancy[i];
          res.average = sum / (hi - lo);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_BINS; i++) occupancy[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Every accepted input beat is predicted at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      awaited_results.push_back(apply_occupancy_op(s_tuser, s_tdata[TIME_W-1:0],
                                                   s_tdata[TIME_W+QBIN_W-1:TIME_W]));
      in_beats <= in_beats + 1;
    end
  end

  // Every accepted result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    occupancy_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat, average %0d status %0d", $time,
                 m_tdata[31:0], m_tdata[32]);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (m_tdata[31:0] !== want.average) begin
          $display("%0t: average expected %0d got %0d", $time, want.average, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[32] !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, m_tdata[32]);
          mismatches++;
        end
      end
    end
  end

  // Receiver back-pressure: mostly ready, with short and occasional long stalls.
  always @(negedge clk) begin
    int unsigned r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!idling_on) begin
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        if (r < 94) stall_left <= $urandom_range(0, 2);
        else if (r < 98) stall_left <= $urandom_range(3, 15);
        else stall_left <= $urandom_range(30, 120);
      end
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // Sends one beat; called and returns at a falling edge.
  task automatic send_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] ctime,
                           logic [QBIN_W-1:0] qbin);
    int unsigned gap, target;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_TDATA_W-TIME_W-QBIN_W){1'b0}}, qbin, ctime};
    target = in_beats + 1;
    do @(negedge clk); while (in_beats < target);
  endtask

  // Waits until every predicted result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // Register write while the block is idle; the shadow follows the masked value.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_we    <= 1'b1;
    case (idx)
      REG_BIN_WIDTH:   bin_width = value;
      REG_WINDOW_HALF: window_half = value[WIN_W-1:0];
      REG_ACTIVE_BINS: active_bins = value[ACT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Behavior under the reset register values.
  task automatic test_reset_defaults();
    send_item(OP_ADD, 20'd0, 10'd0);
    send_item(OP_ADD, 20'd0, 10'h3FF);
    send_item(OP_ADD, 20'd1023, 10'd0);
    // Bins past the active range are flagged and dropped.
    send_item(OP_ADD, 20'd1024, 10'd0);
    send_item(OP_ADD, 20'hFFFFF, 10'h3FF);
    send_item(OP_QUERY, 20'hFFFFF, 10'd0);
    send_item(OP_QUERY, 20'd0, 10'd1023);
    send_item(OP_QUERY, 20'd0, 10'd5);
    // The unused opcode does nothing and answers zero.
    send_item(OP_UNUSED, 20'hFFFFF, 10'h3FF);
    send_item(OP_CLEAR, 20'd0, 10'd0);
    send_item(OP_QUERY, 20'd0, 10'd0);
    drain();
  endtask

  // Register extremes: widest bins and window, zero active bins, zero bin width.
  task automatic test_register_extremes();
    write_reg(REG_BIN_WIDTH, 16'hFFFF);
    write_reg(REG_WINDOW_HALF, 16'hFFFF);
    write_reg(REG_ACTIVE_BINS, 16'hFFFF);
    send_item(OP_ADD, 20'd0, 10'd0);
    send_item(OP_ADD, 20'hFFFFF, 10'd0);
    send_item(OP_ADD, 20'(7 * 65535), 10'd0);
    send_item(OP_QUERY, 20'd0, 10'd0);
    send_item(OP_QUERY, 20'd0, 10'd1023);
    send_item(OP_QUERY, 20'd0, 10'd512);
    drain();
    // Active bins of zero: everything is flagged.
    write_reg(REG_ACTIVE_BINS, 16'hF800);
    send_item(OP_ADD, 20'd0, 10'd0);
    send_item(OP_QUERY, 20'd0, 10'd0);
    drain();
    // A zero bin width drops every add; a single active bin clamps the window.
    write_reg(REG_ACTIVE_BINS, 16'd1);
    write_reg(REG_BIN_WIDTH, 16'd0);
    send_item(OP_ADD, 20'd5, 10'd0);
    send_item(OP_QUERY, 20'd0, 10'd0);
    send_item(OP_QUERY, 20'd0, 10'd1);
    drain();
  endtask

  function automatic logic [TIME_W-1:0] pick_add_time();
    int unsigned nact, bin, t, r;
    nact = live_bins();
    t = $urandom & 32'hFFFFF;
    if (bin_width == 0 || nact == 0 || $urandom_range(0, 9) == 0) return t[TIME_W-1:0];
    r = $urandom_range(0, 9);
    if (r == 0) bin = nact;
    else if (r < 5) bin = $urandom_range(0, ((nact < 8) ? nact : 8) - 1);
    else bin = $urandom_range(0, nact - 1);
    t = bin * bin_width + $urandom_range(0, bin_width - 1);
    if (t > 32'hFFFFF) t = $urandom & 32'hFFFFF;
    return t[TIME_W-1:0];
  endfunction

  function automatic logic [QBIN_W-1:0] pick_query_bin();
    int unsigned nact, bin, r;
    nact = live_bins();
    bin = $urandom & 32'h3FF;
    r = $urandom_range(0, 9);
    if (nact == 0 || r == 0) return bin[QBIN_W-1:0];
    if (r == 1) bin = (nact < MAX_BINS) ? nact : MAX_BINS - 1;
    else if (r == 2) bin = nact - 1;
    else if (r == 3) bin = 0;
    else bin = $urandom_range(0, nact - 1);
    return bin[QBIN_W-1:0];
  endfunction

  // Random register settings with the extremes weighted in; upper data bits are noise.
  task automatic pick_settings();
    int unsigned r, bw, win, act;
    r = $urandom_range(0, 19);
    if (r == 0) bw = 0;
    else if (r < 4) bw = 1;
    else if (r == 4) bw = 65535;
    else if (r < 15) bw = $urandom_range(1, 64);
    else bw = $urandom_range(1, 65535);
    r = $urandom_range(0, 19);
    if (r < 5) win = 0;
    else if (r < 7) win = 255;
    else if (r < 16) win = $urandom_range(1, 8);
    else win = $urandom_range(0, 255);
    r = $urandom_range(0, 19);
    if (r == 0) act = 0;
    else if (r < 3) act = 1;
    else if (r < 5) act = 1024;
    else if (r < 7) act = $urandom_range(1025, 2047);
    else if (r < 15) act = $urandom_range(2, 64);
    else act = $urandom_range(1, 1024);
    write_reg(REG_BIN_WIDTH, bw[15:0]);
    write_reg(REG_WINDOW_HALF, {8'($urandom), win[7:0]});
    write_reg(REG_ACTIVE_BINS, {5'($urandom), act[10:0]});
  endtask

  // Random phases: mostly adds and queries, some clears, unused opcodes and noise.
  task automatic test_random_traffic();
    int unsigned r;
    logic [31:0] noise;
    for (int p = 0; p < PHASES; p++) begin
      pick_settings();
      idling_on = (p != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        noise = $urandom;
        if (r < 60) send_item(OP_ADD, pick_add_time(), noise[QBIN_W-1:0]);
        else if (r < 88) send_item(OP_QUERY, noise[TIME_W-1:0], pick_query_bin());
        else if (r < 91) send_item(OP_CLEAR, noise[TIME_W-1:0], noise[31:22]);
        else if (r < 95) send_item(OP_UNUSED, noise[TIME_W-1:0], noise[31:22]);
        else send_item(OP_ADD, noise[TIME_W-1:0], noise[31:22]);
      end
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: time_bin_occupancy_averager.f
hw/rtl/tboa_pkg.sv
hw/rtl/tboa_div.sv
hw/rtl/time_bin_occupancy_averager.sv
hw/rtl/tboa_checker.sv
tb/tb_time_bin_occupancy_averager.sv
